FILE: src/banded_heat_cool_pid_macros.svh
// Assertion macros shared by the banded heat/cool controller RTL.
`ifndef BANDED_HEAT_COOL_PID_MACROS_SVH
`define BANDED_HEAT_COOL_PID_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define BHC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("bhc assertion failed");

// Expression must never be true outside reset.
`define BHC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("bhc forbidden condition seen");

`else

`define BHC_ASSERT(lbl, clk, rst, prop)
`define BHC_ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

FILE: src/bhc_pkg.sv
// Types, constants and microprogram of the banded heat/cool controller.
`default_nettype none

package bhc_pkg;

   // field widths
   localparam int TEMP_WIDTH     = 16;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int GAIN_W         = 16;
   localparam int DUTY_W         = 10;
   localparam int BAND_W         = 3;
   localparam int PID_W          = 32;
   localparam int DIFF_W         = TEMP_WIDTH + 1;
   localparam int ERR_W          = 8;
   localparam int MUL_B_W        = ERR_W + 3;
   localparam int PROD_W         = GAIN_W + 1 + MUL_B_W;
   localparam int ACC_W          = PID_W;
   localparam int SUM_W          = ACC_W + 10;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 16;

   // control constants
   localparam int FULL_DUTY  = 1000;
   localparam int BAND_OUTER = 100;
   localparam int BAND_INNER = 20;
   localparam int HEAT_BASE  = 250;
   localparam int COOL_BASE  = 750;

   localparam logic signed [DIFF_W-1:0] D_OUTER_POS = DIFF_W'(BAND_OUTER);
   localparam logic signed [DIFF_W-1:0] D_OUTER_NEG = DIFF_W'(-BAND_OUTER);
   localparam logic signed [DIFF_W-1:0] D_INNER_POS = DIFF_W'(BAND_INNER);
   localparam logic signed [DIFF_W-1:0] D_INNER_NEG = DIFF_W'(-BAND_INNER);

   // reset values of the registers
   localparam logic [TEMP_WIDTH-1:0] SETPOINT_RST = TEMP_WIDTH'(2000);
   localparam logic [GAIN_W-1:0]     GAIN_P_RST   = GAIN_W'(2560);
   localparam logic [GAIN_W-1:0]     GAIN_I_RST   = GAIN_W'(128);
   localparam logic [GAIN_W-1:0]     GAIN_D_RST   = GAIN_W'(0);
   localparam logic [DUTY_W-1:0]     HOLD_RST     = DUTY_W'(100);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SETPOINT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 3'd4;

   typedef enum logic [BAND_W-1:0] {
      BAND_FULL_HEAT = 3'd0,
      BAND_FULL_COOL = 3'd1,
      BAND_PID_HEAT  = 3'd2,
      BAND_PID_COOL  = 3'd3,
      BAND_HOLD      = 3'd4
   } band_type;

   typedef struct packed {
      logic [TEMP_WIDTH-1:0] setpoint;
      logic [GAIN_W-1:0]     gain_p;
      logic [GAIN_W-1:0]     gain_i;
      logic [GAIN_W-1:0]     gain_d;
      logic [DUTY_W-1:0]     hold_cool_duty;
   } cfg_type;

   // microcode fields
   typedef enum logic [1:0] {MUL_NONE, MUL_P, MUL_I, MUL_D} mul_sel_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_type;
   typedef enum logic [1:0] {JC_NONE, JC_NO_REQ, JC_NOT_PID, JC_OUT_BUSY} jump_cond_type;

   localparam int UCODE_DEPTH = 6;
   localparam int PC_W        = $clog2(UCODE_DEPTH);

   localparam logic [PC_W-1:0] STEP_WAIT = 3'd0;
   localparam logic [PC_W-1:0] STEP_MULP = 3'd1;
   localparam logic [PC_W-1:0] STEP_MULI = 3'd2;
   localparam logic [PC_W-1:0] STEP_MULD = 3'd3;
   localparam logic [PC_W-1:0] STEP_DUTY = 3'd4;
   localparam logic [PC_W-1:0] STEP_OUT  = 3'd5;
   localparam logic [PC_W-1:0] STEP_LAST = STEP_OUT;

   typedef struct packed {
      logic          accept;
      mul_sel_type   mul_sel;
      acc_op_type    acc_op;
      logic          err_upd;
      logic          duty_en;
      logic          out_load;
      jump_cond_type jump_cond;
      logic [PC_W-1:0] target;
   } ucode_word_type;

   // status fed back to the sequencer for its jumps
   typedef struct packed {
      logic req_valid;
      logic pid_band;
      logic out_busy;
   } seq_status_type;

   localparam ucode_word_type UCODE_ROM [UCODE_DEPTH] = '{
      // wait for a sample, latch the error
      '{accept: 1'b1, mul_sel: MUL_NONE, acc_op: ACC_HOLD, err_upd: 1'b0,
        duty_en: 1'b0, out_load: 1'b0, jump_cond: JC_NO_REQ, target: STEP_WAIT},
      // Kp * (e - last); bands without PID skip to the duty step
      '{accept: 1'b0, mul_sel: MUL_P, acc_op: ACC_LOAD, err_upd: 1'b0,
        duty_en: 1'b0, out_load: 1'b0, jump_cond: JC_NOT_PID, target: STEP_DUTY},
      // + Ki * e
      '{accept: 1'b0, mul_sel: MUL_I, acc_op: ACC_ADD, err_upd: 1'b0,
        duty_en: 1'b0, out_load: 1'b0, jump_cond: JC_NONE, target: STEP_WAIT},
      // + Kd * (e - 2 last + prior), shift error history
      '{accept: 1'b0, mul_sel: MUL_D, acc_op: ACC_ADD, err_upd: 1'b1,
        duty_en: 1'b0, out_load: 1'b0, jump_cond: JC_NONE, target: STEP_WAIT},
      // base + 250 * value
      '{accept: 1'b0, mul_sel: MUL_NONE, acc_op: ACC_HOLD, err_upd: 1'b0,
        duty_en: 1'b1, out_load: 1'b0, jump_cond: JC_NONE, target: STEP_WAIT},
      // saturate and hand to the output register, wait while it is full
      '{accept: 1'b0, mul_sel: MUL_NONE, acc_op: ACC_HOLD, err_upd: 1'b0,
        duty_en: 1'b0, out_load: 1'b1, jump_cond: JC_OUT_BUSY, target: STEP_OUT}
   };

endpackage

`default_nettype wire

FILE: src/banded_heat_cool_pid.sv
// Top level of the banded heat/cool temperature controller.
//
// Usage:
//   req_*  : one temperature sample per transfer (tdata[15:0], 0.01 degree).
//   rsp_*  : one result per sample; tdata carries heat duty, cool duty and
//            the PID term, tuser the band code.
//   csr_*  : register writes (setpoint, three gains, hold cooling duty),
//            always ready; write only while no sample is in flight.
// Sequencing: a sample in a PID band passes the wait, P, I, D, duty and
//   output steps; other bands jump from the P step to the duty step.
// One sample is taken at a time, the next only once the sequencer is back
//   at its wait step. The six-step microprogram uses a single shared
//   multiplier that forms the P, I and D products one after the other.
// Reset: step counter to the wait step, registers to their defaults, error
//   history to zero, output register empty.
// Stall: the result sits in the output register; the next sample is taken
//   and computed meanwhile, and the sequencer holds at its output step
//   until the register frees.
`default_nettype none
`include "banded_heat_cool_pid_macros.svh"

module banded_heat_cool_pid (
   input  wire         clock,
   input  wire         reset,
   // sample in: [15:0] measured_temp
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,
   // result: [9:0] heat_duty, [19:10] cool_duty, [51:20] pid_value, rest zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [55:0] rsp_tdata,
   // result kind: [2:0] band
   output logic [2:0]  rsp_tuser,
   // register writes
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [2:0]  csr_index,
   input  wire  [15:0] csr_wdata
);

   bhc_pkg::cfg_type          cfg_ff, cfg_in;
   bhc_pkg::ucode_word_type   ctl;
   bhc_pkg::seq_status_type   status;

   logic                          req_take;
   logic                          csr_take;
   logic                          pid_band;
   logic                          out_busy;
   logic                          rsp_load;
   logic [bhc_pkg::DUTY_W-1:0]    heat_duty, cool_duty;
   logic [bhc_pkg::BAND_W-1:0]    band;
   logic [bhc_pkg::PID_W-1:0]     pid_value;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bhc_pkg::DUTY_W-1:0]    heat_ff, cool_ff;
   logic [bhc_pkg::BAND_W-1:0]    band_ff;
   logic [bhc_pkg::PID_W-1:0]     pid_ff;

   // ---- register file ----
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_take) begin
         unique case (csr_index)
            bhc_pkg::CSR_SETPOINT: cfg_in.setpoint       = csr_wdata;
            bhc_pkg::CSR_GAIN_P:   cfg_in.gain_p         = csr_wdata;
            bhc_pkg::CSR_GAIN_I:   cfg_in.gain_i         = csr_wdata;
            bhc_pkg::CSR_GAIN_D:   cfg_in.gain_d         = csr_wdata;
            bhc_pkg::CSR_HOLD:     cfg_in.hold_cool_duty = csr_wdata[bhc_pkg::DUTY_W-1:0];
            default:               cfg_in = cfg_ff;   // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint       <= bhc_pkg::SETPOINT_RST;
         cfg_ff.gain_p         <= bhc_pkg::GAIN_P_RST;
         cfg_ff.gain_i         <= bhc_pkg::GAIN_I_RST;
         cfg_ff.gain_d         <= bhc_pkg::GAIN_D_RST;
         cfg_ff.hold_cool_duty <= bhc_pkg::HOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---- control ----
   assign req_tready = ctl.accept;
   assign req_take   = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;

   assign status.req_valid = req_tvalid;
   assign status.pid_band  = pid_band;
   assign status.out_busy  = out_busy;

   bhc_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   bhc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .cfg       (cfg_ff),
      .req_take  (req_take),
      .req_temp  (req_tdata[bhc_pkg::TEMP_WIDTH-1:0]),
      .pid_band  (pid_band),
      .heat_duty (heat_duty),
      .cool_duty (cool_duty),
      .band      (band),
      .pid_value (pid_value)
   );

   // ---- output register: loads when empty or emptied this cycle ----
   assign rsp_load = ctl.out_load && !out_busy;

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         heat_ff <= heat_duty;
         cool_ff <= cool_duty;
         band_ff <= band;
         pid_ff  <= pid_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, pid_ff, cool_ff, heat_ff};
   assign rsp_tuser  = band_ff;

   // ---- checks ----
   `BHC_ASSERT(a_duty_range, clock, reset, rsp_valid_ff |-> (heat_ff <= 10'd1000 && cool_ff <= 10'd1000))
   `BHC_ASSERT(a_pid_zero_outside, clock, reset, (rsp_valid_ff && band_ff != bhc_pkg::BAND_PID_HEAT && band_ff != bhc_pkg::BAND_PID_COOL) |-> (pid_ff == '0))
   `BHC_ASSERT(a_one_sample_at_a_time, clock, reset, req_take |=> !req_tready)

endmodule

`default_nettype wire

FILE: src/bhc_sequencer.sv
// Microcode sequencer: step counter, control store lookup and jumps.
`default_nettype none

module bhc_sequencer (
   input  wire                       clock,
   input  wire                       reset,
   input  bhc_pkg::seq_status_type   status,
   output bhc_pkg::ucode_word_type   ctl
);

   logic [bhc_pkg::PC_W-1:0] pc_ff;
   logic [bhc_pkg::PC_W-1:0] pc_in;
   logic                     taken;

   assign ctl = bhc_pkg::UCODE_ROM[pc_ff];

   always_comb begin
      unique case (ctl.jump_cond)
         bhc_pkg::JC_NONE:     taken = 1'b0;
         bhc_pkg::JC_NO_REQ:   taken = !status.req_valid;
         bhc_pkg::JC_NOT_PID:  taken = !status.pid_band;
         bhc_pkg::JC_OUT_BUSY: taken = status.out_busy;
         default:              taken = 1'b0;
      endcase
   end

   always_comb begin
      if (taken) begin
         pc_in = ctl.target;
      end else if (pc_ff == bhc_pkg::STEP_LAST) begin
         pc_in = bhc_pkg::STEP_WAIT;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= bhc_pkg::STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/bhc_datapath.sv
// Datapath: error, band select, shared PID multiplier, duty saturation.
`default_nettype none

module bhc_datapath (
   input  wire                                clock,
   input  wire                                reset,
   input  bhc_pkg::ucode_word_type            ctl,
   input  bhc_pkg::cfg_type                   cfg,
   input  wire                                req_take,
   input  wire  [bhc_pkg::TEMP_WIDTH-1:0]     req_temp,
   output logic                               pid_band,
   output logic [bhc_pkg::DUTY_W-1:0]         heat_duty,
   output logic [bhc_pkg::DUTY_W-1:0]         cool_duty,
   output logic [bhc_pkg::BAND_W-1:0]         band,
   output logic [bhc_pkg::PID_W-1:0]          pid_value
);

   localparam int TW  = bhc_pkg::TEMP_WIDTH;
   localparam int EW  = bhc_pkg::ERR_W;
   localparam int BW  = bhc_pkg::MUL_B_W;
   localparam int PW  = bhc_pkg::PROD_W;
   localparam int AW  = bhc_pkg::ACC_W;
   localparam int SW  = bhc_pkg::SUM_W;
   localparam int GFB = bhc_pkg::GAIN_FRAC_BITS;
   localparam int QW  = SW - GFB;

   logic signed [bhc_pkg::DIFF_W-1:0] d_ff, d_in;
   logic [EW-1:0]          last_ff, last_in, prior_ff, prior_in;
   logic signed [AW-1:0]   acc_ff, acc_in;
   logic signed [SW-1:0]   sum_ff, sum_in;

   bhc_pkg::band_type      band_sel;
   logic signed [BW-1:0]   e_x, l_x, p_x, diff_p, diff_d, mul_b;
   logic [bhc_pkg::GAIN_W-1:0] mul_a;
   logic signed [PW-1:0]   prod;
   logic signed [AW-1:0]   prod_x;
   logic signed [SW-1:0]   acc_x, base_x;
   logic [QW-1:0]          quot;
   logic [bhc_pkg::DUTY_W-1:0] pid_duty, hold_duty;

   // error d = setpoint - measured, one bit wider than a temperature
   assign d_in = $signed({cfg.setpoint[TW-1], cfg.setpoint})
               - $signed({req_temp[TW-1], req_temp});

   always_comb begin
      if (d_ff > bhc_pkg::D_OUTER_POS) begin
         band_sel = bhc_pkg::BAND_FULL_HEAT;
      end else if (d_ff < bhc_pkg::D_OUTER_NEG) begin
         band_sel = bhc_pkg::BAND_FULL_COOL;
      end else if (d_ff >= bhc_pkg::D_INNER_POS) begin
         band_sel = bhc_pkg::BAND_PID_HEAT;
      end else if (d_ff <= bhc_pkg::D_INNER_NEG) begin
         band_sel = bhc_pkg::BAND_PID_COOL;
      end else begin
         band_sel = bhc_pkg::BAND_HOLD;
      end
   end

   assign pid_band = (band_sel == bhc_pkg::BAND_PID_HEAT)
                  || (band_sel == bhc_pkg::BAND_PID_COOL);

   // error terms; in the PID bands e lies within +-100 and fits 8 bits
   assign e_x    = $signed({{(BW-EW){d_ff[EW-1]}}, d_ff[EW-1:0]});
   assign l_x    = $signed({{(BW-EW){last_ff[EW-1]}}, last_ff});
   assign p_x    = $signed({{(BW-EW){prior_ff[EW-1]}}, prior_ff});
   assign diff_p = e_x - l_x;
   assign diff_d = e_x - (l_x <<< 1) + p_x;

   always_comb begin
      case (ctl.mul_sel)
         bhc_pkg::MUL_P: begin
            mul_a = cfg.gain_p;
            mul_b = diff_p;
         end
         bhc_pkg::MUL_I: begin
            mul_a = cfg.gain_i;
            mul_b = e_x;
         end
         bhc_pkg::MUL_D: begin
            mul_a = cfg.gain_d;
            mul_b = diff_d;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod   = $signed({1'b0, mul_a}) * mul_b;
   assign prod_x = $signed({{(AW-PW){prod[PW-1]}}, prod});

   always_comb begin
      case (ctl.acc_op)
         bhc_pkg::ACC_LOAD: acc_in = prod_x;
         bhc_pkg::ACC_ADD:  acc_in = acc_ff + prod_x;
         default:           acc_in = acc_ff;
      endcase
   end

   // base << frac + 250 * value, the 250 as 256 - 4 - 2
   assign acc_x  = $signed({{(SW-AW){acc_ff[AW-1]}}, acc_ff});
   assign base_x = (band_sel == bhc_pkg::BAND_PID_HEAT)
                 ? (SW'(bhc_pkg::HEAT_BASE) <<< GFB)
                 : (SW'(bhc_pkg::COOL_BASE) <<< GFB);
   assign sum_in = ctl.duty_en
                 ? base_x + (acc_x <<< 8) - (acc_x <<< 2) - (acc_x <<< 1)
                 : sum_ff;

   always_comb begin
      last_in  = last_ff;
      prior_in = prior_ff;
      if (ctl.err_upd) begin
         prior_in = last_ff;
         last_in  = d_ff[EW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff  <= '0;
         prior_ff <= '0;
      end else begin
         last_ff  <= last_in;
         prior_ff <= prior_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         d_ff <= d_in;
      end
      acc_ff <= acc_in;
      sum_ff <= sum_in;
   end

   // truncate, then clamp to 0..1000
   assign quot = sum_ff[SW-1:GFB];
   always_comb begin
      if (sum_ff[SW-1]) begin
         pid_duty = '0;
      end else if (quot > QW'(bhc_pkg::FULL_DUTY)) begin
         pid_duty = bhc_pkg::DUTY_W'(bhc_pkg::FULL_DUTY);
      end else begin
         pid_duty = quot[bhc_pkg::DUTY_W-1:0];
      end
   end

   assign hold_duty = (cfg.hold_cool_duty > bhc_pkg::DUTY_W'(bhc_pkg::FULL_DUTY))
                    ? bhc_pkg::DUTY_W'(bhc_pkg::FULL_DUTY) : cfg.hold_cool_duty;

   always_comb begin
      heat_duty = '0;
      cool_duty = '0;
      pid_value = '0;
      unique case (band_sel)
         bhc_pkg::BAND_FULL_HEAT: heat_duty = bhc_pkg::DUTY_W'(bhc_pkg::FULL_DUTY);
         bhc_pkg::BAND_FULL_COOL: cool_duty = bhc_pkg::DUTY_W'(bhc_pkg::FULL_DUTY);
         bhc_pkg::BAND_PID_HEAT: begin
            heat_duty = pid_duty;
            pid_value = acc_ff;
         end
         bhc_pkg::BAND_PID_COOL: begin
            cool_duty = pid_duty;
            pid_value = acc_ff;
         end
         bhc_pkg::BAND_HOLD:      cool_duty = hold_duty;
         default: begin
            heat_duty = '0;
         end
      endcase
   end

   assign band = band_sel;

endmodule

`default_nettype wire

FILE: tb/sv/banded_heat_cool_pid_tb.sv
// Self-checking testbench for the banded heat/cool controller: directed and random samples.
`timescale 1ns / 1ps

module banded_heat_cool_pid_tb;
   import bhc_pkg::*;

   localparam int           DUTY_SLOPE    = 250;
   localparam int           SETTLE_CYCLES = 12;      // covers the PID latency
   localparam int           CYCLE_LIMIT   = 400000;
   localparam int           PRINT_LIMIT   = 50;
   localparam logic [2:0]   CSR_UNUSED    = 3'd7;    // no register behind this index

   // traffic shaping per phase
   typedef enum {FLOW_FREE, FLOW_SENDER_IDLE, FLOW_RECEIVER_STALL, FLOW_BOTH} flow_type;

   typedef struct {
      logic [DUTY_W-1:0] heat;
      logic [DUTY_W-1:0] cool;
      band_type          band;
      logic [PID_W-1:0]  pid;
   } duty_result_type;

   // Shadow of the controller: registers, error history and results in flight.
   class duty_scoreboard;
      int                setpoint;
      int                gain_p;
      int                gain_i;
      int                gain_d;
      int                hold_duty;
      logic signed [7:0] last_err;
      logic signed [7:0] prior_err;
      duty_result_type   pending_duties[$];
      int                mismatches;
      int                results_seen;

      function new();
         setpoint  = $signed(SETPOINT_RST);
         gain_p    = GAIN_P_RST;
         gain_i    = GAIN_I_RST;
         gain_d    = GAIN_D_RST;
         hold_duty = HOLD_RST;
         last_err  = '0;
         prior_err = '0;
         mismatches   = 0;
         results_seen = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [15:0] data);
         case (index)
            CSR_SETPOINT: setpoint  = $signed(data);
            CSR_GAIN_P:   gain_p    = data;
            CSR_GAIN_I:   gain_i    = data;
            CSR_GAIN_D:   gain_d    = data;
            CSR_HOLD:     hold_duty = data[DUTY_W-1:0];
            default: ;
         endcase
      endfunction

      // base + 250*value, truncated, clamped to 0..1000
      function logic [DUTY_W-1:0] duty_from_pid(longint base, longint value);
         longint sum;
         longint q;
         sum = base * (longint'(1) << GAIN_FRAC_BITS) + DUTY_SLOPE * value;
         if (sum < 0) return '0;
         q = sum >>> GAIN_FRAC_BITS;
         return (q > FULL_DUTY) ? DUTY_W'(FULL_DUTY) : DUTY_W'(q);
      endfunction

      function void note_sample(logic [TEMP_WIDTH-1:0] temp);
         int              tp;
         longint          diff;
         longint          prev;
         longint          older;
         longint          value;
         duty_result_type r;
         tp     = $signed(temp);
         diff   = setpoint - tp;
         r.heat = '0;
         r.cool = '0;
         r.pid  = '0;
         if (diff > BAND_OUTER) begin
            r.band = BAND_FULL_HEAT;
            r.heat = DUTY_W'(FULL_DUTY);
         end else if (diff < -BAND_OUTER) begin
            r.band = BAND_FULL_COOL;
            r.cool = DUTY_W'(FULL_DUTY);
         end else if (diff >= BAND_INNER || diff <= -BAND_INNER) begin
            prev  = last_err;
            older = prior_err;
            value = gain_p * (diff - prev) + gain_i * diff
                  + gain_d * (diff - 2 * prev + older);
            prior_err = last_err;
            last_err  = diff[7:0];
            r.pid     = value[PID_W-1:0];
            if (diff > 0) begin
               r.band = BAND_PID_HEAT;
               r.heat = duty_from_pid(HEAT_BASE, value);
            end else begin
               r.band = BAND_PID_COOL;
               r.cool = duty_from_pid(COOL_BASE, value);
            end
         end else begin
            r.band = BAND_HOLD;
            r.cool = (hold_duty > FULL_DUTY) ? DUTY_W'(FULL_DUTY) : DUTY_W'(hold_duty);
         end
         pending_duties.push_back(r);
      endfunction

      task report_mismatch(string field, longint got, longint want);
         if (mismatches < PRINT_LIMIT)
            $display("[%0t] result %0d: %s got %0d, want %0d",
                     $time, results_seen, field, got, want);
         mismatches++;
      endtask

      task check_result(logic [55:0] data, logic [2:0] kind);
         duty_result_type want;
         if (pending_duties.size() == 0) begin
            report_mismatch("unexpected result, pending count", 1, 0);
         end else begin
            want = pending_duties.pop_front();
            if (data[9:0] !== want.heat)
               report_mismatch("heat_duty", data[9:0], want.heat);
            if (data[19:10] !== want.cool)
               report_mismatch("cool_duty", data[19:10], want.cool);
            if (data[51:20] !== want.pid)
               report_mismatch("pid_value", $signed(data[51:20]), $signed(want.pid));
            if (data[55:52] !== 4'b0)
               report_mismatch("tdata pad bits", data[55:52], 0);
            if (kind !== want.band)
               report_mismatch("band", kind, want.band);
         end
         results_seen++;
      endtask

      function int pending();
         return pending_duties.size();
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [15:0] csr_wdata  = '0;

   duty_scoreboard sb;
   flow_type       flow = FLOW_FREE;
   int             cycle_count = 0;

   banded_heat_cool_pid DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [15:0] measured_temp
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // [9:0] heat, [19:10] cool, [51:20] pid, [55:52] zero
      .rsp_tuser  (rsp_tuser),    // [2:0] band
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("banded_heat_cool_pid: mismatch");
      $finish;
   end

   function automatic int sender_idle_pct();
      case (flow)
         FLOW_SENDER_IDLE: return 78;
         FLOW_BOTH:        return 36;
         default:          return 0;
      endcase
   endfunction

   function automatic int receiver_stall_pct();
      case (flow)
         FLOW_RECEIVER_STALL: return 78;
         FLOW_BOTH:           return 36;
         default:             return 0;
      endcase
   endfunction

   // Result side. Handshake signals are read right after the edge, so they
   // still hold the values the DUT saw at that edge; tready is then redrawn.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tuser);
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct());
      end
   end

   // One sample transfer. tvalid is left high after acceptance so back-to-back
   // samples need no extra assignment; the next call or the caller lowers it.
   task automatic send_sample(logic [15:0] temp);
      while ($urandom_range(0, 99) < sender_idle_pct()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= temp;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(temp);
   endtask

   // csr_valid stays high across a batch of writes; the batch task lowers it.
   task automatic write_register(logic [2:0] index, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(index, data);
   endtask

   task automatic apply_settings(int sp, int kp, int ki, int kd, int hold);
      write_register(CSR_SETPOINT, 16'(sp));
      write_register(CSR_GAIN_P, 16'(kp));
      write_register(CSR_GAIN_I, 16'(ki));
      write_register(CSR_GAIN_D, 16'(kd));
      write_register(CSR_HOLD, 16'(hold));
      // a write to an unmapped index must leave every register alone
      write_register(CSR_UNUSED, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Block must be idle before any register write: every result back,
   // plus a settling margin of SETTLE_CYCLES on the sequencer.
   task automatic drain_results();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // The largest share of samples lands in the PID bands so they and their error
   // history get real work; the rest are band edges, dead band and raw noise.
   function automatic logic [15:0] pick_temp();
      int roll;
      int dist_err;
      roll = $urandom_range(0, 99);
      if (roll < 15)
         return 16'($urandom);
      if (roll < 60)
         dist_err = $urandom_range(BAND_INNER, BAND_OUTER);
      else if (roll < 80)
         dist_err = $urandom_range(0, BAND_INNER - 1);
      else
         dist_err = $urandom_range(BAND_OUTER - 5, BAND_OUTER + 30);
      if ($urandom_range(0, 1)) dist_err = -dist_err;
      return 16'(sb.setpoint - dist_err);
   endfunction

   task automatic run_phase(flow_type mode, int count, bit hold_off);
      flow = mode;
      for (int i = 0; i < count; i++) begin
         // sender holds off until the pipe is fully empty
         if (hold_off && i == count / 2) begin
            req_tvalid <= 1'b0;
            drain_results();
         end
         send_sample(pick_temp());
      end
      req_tvalid <= 1'b0;
      drain_results();
   endtask

   // error offsets for the directed part, against the reset setpoint;
   // 21 after 22 (and -21 after -22) gives in-range PID duties
   int directed_errs[] = '{101, 100, 20, 19, 0, -19, -20, -100, -101,
                           22, 21, -22, -21, 60, -60};

   initial begin
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: band edges, dead band, duty clamps at both ends, raw extremes
      flow = FLOW_FREE;
      foreach (directed_errs[k])
         send_sample(16'(sb.setpoint - directed_errs[k]));
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'hFFFF);
      send_sample(16'h0000);
      req_tvalid <= 1'b0;
      drain_results();

      // register extremes, then random settings across the traffic modes
      apply_settings(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, FULL_DUTY);
      run_phase(FLOW_FREE, 180, 1'b0);

      apply_settings(-32768, 0, 0, 0, 0);
      run_phase(FLOW_SENDER_IDLE, 180, 1'b0);

      // hold duty written above its range, upper data bits set
      apply_settings(32767, $urandom_range(0, 65535), $urandom_range(0, 65535),
                     $urandom_range(0, 65535), 16'hFFFF);
      run_phase(FLOW_RECEIVER_STALL, 180, 1'b0);

      apply_settings(2000, $urandom_range(0, 1023), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, FULL_DUTY));
      run_phase(FLOW_BOTH, 220, 1'b1);

      apply_settings($urandom_range(0, 65535), $urandom_range(0, 2047),
                     $urandom_range(0, 511), $urandom_range(0, 511),
                     $urandom_range(0, 65535));
      run_phase(FLOW_SENDER_IDLE, 220, 1'b0);

      apply_settings($urandom_range(0, 4000) - 2000, $urandom_range(0, 511),
                     $urandom_range(0, 127), $urandom_range(0, 1023),
                     $urandom_range(0, 1023));
      run_phase(FLOW_BOTH, 220, 1'b0);

      if (sb.mismatches == 0)
         $display("banded_heat_cool_pid: match");
      else
         $display("banded_heat_cool_pid: mismatch");
      $finish;
   end

endmodule
